/* rtl/core/rgps_pkg.sv */
// Ring glow pixel shader: shared types and fixed codes.
// No dependencies; imported by every rgps cell and by the top level.
package rgps_pkg;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] LEVEL_MAX    = 8'hFF;

  // per-cycle control handed to every cell of a chain
  typedef struct packed {
    logic en;
    logic vld;
  } rgps_step_t;

endpackage

/* rtl/core/rgps_div_cell.sv */
// One restoring-division step: shifts a numerator bit into the remainder
// and a quotient bit into the word. Depends on rgps_pkg.
module rgps_div_cell #(
  parameter int NW = 29,
  parameter int DW = 12
) (
  input  logic                clk,
  input  rgps_pkg::rgps_step_t ctl,
  input  logic [DW-1:0]       rem_i,
  input  logic [NW-1:0]       nq_i,
  input  logic [DW-1:0]       den_i,
  output logic [DW-1:0]       rem_o,
  output logic [NW-1:0]       nq_o,
  output logic [DW-1:0]       den_o
);
  import rgps_pkg::*;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_next;

  assign trial    = {rem_i, nq_i[NW-1]};
  assign diff     = trial - {1'b0, den_i};
  assign ge       = trial >= {1'b0, den_i};
  assign rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.en && ctl.vld) begin
      rem_o <= rem_next;
      nq_o  <= {nq_i[NW-2:0], ge};
      den_o <= den_i;
    end
  end

endmodule

/* rtl/core/rgps_sqrt_cell.sv */
// One digit step of the integer square root: takes two radicand bits,
// yields one root bit. Depends on rgps_pkg.
module rgps_sqrt_cell #(
  parameter int RW = 30
) (
  input  logic                 clk,
  input  rgps_pkg::rgps_step_t ctl,
  input  logic [RW+1:0]        rem_i,
  input  logic [RW-1:0]        root_i,
  input  logic [2*RW-1:0]      n_i,
  output logic [RW+1:0]        rem_o,
  output logic [RW-1:0]        root_o,
  output logic [2*RW-1:0]      n_o
);
  import rgps_pkg::*;

  logic [RW+3:0] acc;
  logic [RW+3:0] test;
  logic [RW+3:0] diff;
  logic          ge;

  assign acc  = {rem_i, n_i[2*RW-1 -: 2]};
  assign test = (RW+4)'({root_i, 2'b01});
  assign diff = acc - test;
  assign ge   = acc >= test;

  always_ff @(posedge clk) begin
    if (ctl.en && ctl.vld) begin
      rem_o  <= ge ? diff[RW+1:0] : acc[RW+1:0];
      root_o <= {root_i[RW-2:0], ge};
      n_o    <= {n_i[2*RW-3:0], 2'b00};
    end
  end

endmodule

/* rtl/core/ring_glow_pixel_shader.sv */
// Ring glow pixel shader: one grey ARGB pixel per coordinate item.
// Depends on rgps_pkg, rgps_div_cell and rgps_sqrt_cell.
//
// Takes one item per clock and keeps one result per clock flowing; the
// pipeline stalls only when the output register is full and not taken.
// Built from three cell chains: the normalizing and ring dividers (one quotient
// bit per cell), the radius square root (one root bit per cell) and the glow
// divider. The quotients are QW = COORD_BITS + FRAC_BITS + 1 bits wide and the
// root is RW = min(QW, 32) + 1 bits wide.
module ring_glow_pixel_shader #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] column,
  input  logic [COORD_BITS-1:0] row,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            intensity,
  output logic [31:0]           argb_color
);
  import rgps_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int FB = FRAC_BITS;
  localparam int QW = CB + FB + 1;
  localparam int TW = (QW > 31) ? 32 : QW;
  localparam int RW = TW + 1;
  localparam int SW = 2 * RW;
  localparam int GW = QW + 1;
  localparam int EW = ((RW > GW) ? RW : GW) + 1;
  localparam int XW = EW + 1;
  localparam int NT = 2 * FB;

  localparam logic [CB-1:0] WIDTH_RST  = CB'(800);
  localparam logic [CB-1:0] HEIGHT_RST = CB'(600);
  localparam logic [FB-1:0] C_HUND     = FB'(((1 << FB) + 50) / 100);
  localparam logic [FB-1:0] C_TENTH    = FB'(((1 << FB) + 5) / 10);
  localparam logic [NT-1:0] ONE_Q      = NT'(1) << FB;
  localparam logic signed [GW-1:0] HALF_G = GW'(1) << (FB - 1);

  typedef struct packed {
    logic neg_d;
    logic zero;
  } dside_t;

  typedef struct packed {
    logic signed [GW-1:0] g;
    logic                 zero;
  } sside_t;

  typedef struct packed {
    logic zero;
    logic hit;
  } qside_t;

  logic [CB-1:0] frame_width;
  logic [CB-1:0] frame_height;
  logic          adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RST;
      frame_height <= HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // front terms
  logic signed [CB+1:0] nu, nv;
  logic signed [CB+2:0] nd;
  logic [CB:0]          mag_u, mag_v;
  logic [CB+1:0]        mag_d;
  logic [FB+CB-1:0]     g_num;
  dside_t               side0;

  assign nu = $signed({1'b0, column, 1'b0}) - $signed({2'b00, frame_width});
  assign nv = $signed({1'b0, row, 1'b0}) - $signed({2'b00, frame_height});
  assign nd = $signed({2'b00, column, 1'b0}) - $signed({2'b00, row, 1'b0})
            + $signed({3'b000, frame_height}) - $signed({3'b000, frame_width});
  assign mag_u = nu[CB+1] ? (CB+1)'(-nu) : nu[CB:0];
  assign mag_v = nv[CB+1] ? (CB+1)'(-nv) : nv[CB:0];
  assign mag_d = nd[CB+2] ? (CB+2)'(-nd) : nd[CB+1:0];
  assign g_num = C_HUND * frame_height;
  assign side0 = '{neg_d: nd[CB+2], zero: (frame_height == '0) || (nd == '0)};

  // divider chain: u, v by height and ring term by |d|
  logic [CB-1:0]   u_rem [0:QW];
  logic [QW-1:0]   u_nq  [0:QW];
  logic [CB-1:0]   u_den [0:QW];
  logic [CB-1:0]   v_rem [0:QW];
  logic [QW-1:0]   v_nq  [0:QW];
  logic [CB-1:0]   v_den [0:QW];
  logic [CB+1:0]   g_rem [0:QW];
  logic [QW-1:0]   g_nq  [0:QW];
  logic [CB+1:0]   g_den [0:QW];
  logic            dvld    [1:QW];
  dside_t          dside   [1:QW];
  logic            dv_src  [0:QW-1];
  dside_t          ds_src  [0:QW-1];

  assign u_rem[0] = '0;
  assign u_nq[0]  = {mag_u, {FB{1'b0}}};
  assign u_den[0] = frame_height;
  assign v_rem[0] = '0;
  assign v_nq[0]  = {mag_v, {FB{1'b0}}};
  assign v_den[0] = frame_height;
  assign g_rem[0] = '0;
  assign g_nq[0]  = QW'(g_num);
  assign g_den[0] = mag_d;

  for (genvar k = 0; k < QW; k++) begin : g_div
    rgps_step_t ctl;

    if (k == 0) begin : g_src0
      assign dv_src[k] = in_valid;
      assign ds_src[k] = side0;
    end else begin : g_srcn
      assign dv_src[k] = dvld[k];
      assign ds_src[k] = dside[k];
    end

    assign ctl = '{en: adv, vld: dv_src[k]};

    rgps_div_cell #(.NW(QW), .DW(CB)) u_cell (
      .clk(clk), .ctl(ctl), .rem_i(u_rem[k]), .nq_i(u_nq[k]), .den_i(u_den[k]),
      .rem_o(u_rem[k+1]), .nq_o(u_nq[k+1]), .den_o(u_den[k+1])
    );
    rgps_div_cell #(.NW(QW), .DW(CB)) v_cell (
      .clk(clk), .ctl(ctl), .rem_i(v_rem[k]), .nq_i(v_nq[k]), .den_i(v_den[k]),
      .rem_o(v_rem[k+1]), .nq_o(v_nq[k+1]), .den_o(v_den[k+1])
    );
    rgps_div_cell #(.NW(QW), .DW(CB+2)) g_cell (
      .clk(clk), .ctl(ctl), .rem_i(g_rem[k]), .nq_i(g_nq[k]), .den_i(g_den[k]),
      .rem_o(g_rem[k+1]), .nq_o(g_nq[k+1]), .den_o(g_den[k+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        dvld[k+1] <= 1'b0;
      end else if (adv) begin
        dvld[k+1] <= dv_src[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv && dv_src[k]) begin
        dside[k+1] <= ds_src[k];
      end
    end
  end

  // clamp, ring radius
  logic [TW-1:0] tu_c, tv_c;

  if (QW > TW) begin : g_clamp
    localparam logic [QW-1:0] LIM = QW'(1) << (TW - 1);
    assign tu_c = (u_nq[QW] > LIM) ? TW'(LIM) : TW'(u_nq[QW]);
    assign tv_c = (v_nq[QW] > LIM) ? TW'(LIM) : TW'(v_nq[QW]);
  end else begin : g_noclamp
    assign tu_c = u_nq[QW];
    assign tv_c = v_nq[QW];
  end

  logic signed [GW-1:0] gq;
  logic                 p1_vld, p2_vld;
  logic [TW-1:0]        p1_tu, p1_tv;
  logic signed [GW-1:0] p1_g, p2_g;
  logic                 p1_zero, p2_zero;
  logic [2*TW-1:0]      p2_usq, p2_vsq;

  assign gq = $signed({1'b0, g_nq[QW]});

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
    end else if (adv) begin
      p1_vld <= dvld[QW];
      p2_vld <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && dvld[QW]) begin
      p1_tu   <= tu_c;
      p1_tv   <= tv_c;
      p1_g    <= HALF_G + (dside[QW].neg_d ? -gq : gq);
      p1_zero <= dside[QW].zero;
    end
    if (adv && p1_vld) begin
      p2_usq  <= p1_tu * p1_tu;
      p2_vsq  <= p1_tv * p1_tv;
      p2_g    <= p1_g;
      p2_zero <= p1_zero;
    end
  end

  // square root chain
  logic [RW+1:0] s_rem  [0:RW];
  logic [RW-1:0] s_root [0:RW];
  logic [SW-1:0] s_n    [0:RW];
  logic          svld   [1:RW];
  sside_t        sside  [1:RW];
  logic          sv_src [0:RW-1];
  sside_t        ss_src [0:RW-1];

  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_n[0]    = SW'(p2_usq) + SW'(p2_vsq);

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    rgps_step_t ctl;

    if (k == 0) begin : g_src0
      assign sv_src[k] = p2_vld;
      assign ss_src[k] = '{g: p2_g, zero: p2_zero};
    end else begin : g_srcn
      assign sv_src[k] = svld[k];
      assign ss_src[k] = sside[k];
    end

    assign ctl = '{en: adv, vld: sv_src[k]};

    rgps_sqrt_cell #(.RW(RW)) sq_cell (
      .clk(clk), .ctl(ctl), .rem_i(s_rem[k]), .root_i(s_root[k]), .n_i(s_n[k]),
      .rem_o(s_rem[k+1]), .root_o(s_root[k+1]), .n_o(s_n[k+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        svld[k+1] <= 1'b0;
      end else if (adv) begin
        svld[k+1] <= sv_src[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv && sv_src[k]) begin
        sside[k+1] <= ss_src[k];
      end
    end
  end

  // distance to ring
  logic signed [XW-1:0] rx, gx, gap;
  logic [EW-1:0]        e_abs;
  logic                 e1_vld;
  logic [EW-1:0]        e1_e;
  qside_t               e1_side;

  assign rx    = XW'(s_root[RW]);
  assign gx    = XW'(sside[RW].g);
  assign gap   = rx - gx;
  assign e_abs = gap[XW-1] ? EW'(-gap) : EW'(gap);

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_vld <= 1'b0;
    end else if (adv) begin
      e1_vld <= svld[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && svld[RW]) begin
      e1_e    <= e_abs;
      e1_side <= '{zero: sside[RW].zero, hit: (e_abs == '0)};
    end
  end

  // glow divider chain
  logic [EW-1:0] q_rem  [0:NT];
  logic [NT-1:0] q_nq   [0:NT];
  logic [EW-1:0] q_den  [0:NT];
  logic          qvld   [1:NT];
  qside_t        qside  [1:NT];
  logic          qv_src [0:NT-1];
  qside_t        qs_src [0:NT-1];

  assign q_rem[0] = '0;
  assign q_nq[0]  = {C_TENTH, {FB{1'b0}}};
  assign q_den[0] = e1_e;

  for (genvar k = 0; k < NT; k++) begin : g_glow
    rgps_step_t ctl;

    if (k == 0) begin : g_src0
      assign qv_src[k] = e1_vld;
      assign qs_src[k] = e1_side;
    end else begin : g_srcn
      assign qv_src[k] = qvld[k];
      assign qs_src[k] = qside[k];
    end

    assign ctl = '{en: adv, vld: qv_src[k]};

    rgps_div_cell #(.NW(NT), .DW(EW)) q_cell (
      .clk(clk), .ctl(ctl), .rem_i(q_rem[k]), .nq_i(q_nq[k]), .den_i(q_den[k]),
      .rem_o(q_rem[k+1]), .nq_o(q_nq[k+1]), .den_o(q_den[k+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        qvld[k+1] <= 1'b0;
      end else if (adv) begin
        qvld[k+1] <= qv_src[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv && qv_src[k]) begin
        qside[k+1] <= qs_src[k];
      end
    end
  end

  // saturate and scale to 0..255
  logic [FB:0]   q_sat;
  logic [FB+8:0] scaled;
  logic [7:0]    level;

  assign q_sat  = (q_nq[NT] > ONE_Q) ? ONE_Q[FB:0] : q_nq[NT][FB:0];
  assign scaled = {q_sat, 8'h00} - {8'h00, q_sat};
  assign level  = qside[NT].zero ? 8'h00 :
                  qside[NT].hit  ? LEVEL_MAX : scaled[FB+7:FB];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= qvld[NT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && qvld[NT]) begin
      intensity <= level;
    end
  end

  assign argb_color = {ALPHA_OPAQUE, intensity, intensity, intensity};

`ifndef NO_ASSERTIONS
  a_pack: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> argb_color[31:24] == ALPHA_OPAQUE && argb_color[23:16] == intensity
      && argb_color[15:8] == intensity && argb_color[7:0] == intensity)
    else $error("argb word does not match intensity");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

/* verif/ring_glow_pixel_shader_tb.sv */
// Testbench for ring_glow_pixel_shader: directed and random pixel items over
// several frame sizes, checked against an in-bench fixed-point glow predictor.
// Depends on rgps_pkg and the ring_glow_pixel_shader RTL.
`timescale 1ns / 1ps

module ring_glow_pixel_shader_tb;
  import rgps_pkg::*;

  localparam int  CB = 12;
  localparam int  FB = 16;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam longint HALF = 64'sd1 <<< (FB - 1);
  localparam longint TENTH = (ONE + 5) / 10;
  localparam longint HUNDREDTH = (ONE + 50) / 100;
  localparam longint TERM_MAX = 64'sd1 <<< 31;
  localparam int  DRAIN_CYCLES = 200;

  typedef struct {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
  } pixel_t;

  typedef struct {
    logic [7:0]  level;
    logic [31:0] argb;
  } shade_t;

  logic          clk;
  logic          rst;
  logic          cfg_write;
  logic          cfg_index;
  logic [CB-1:0] cfg_data;
  logic          in_valid;
  logic          in_ready;
  logic [CB-1:0] column;
  logic [CB-1:0] row;
  logic          out_valid;
  logic          out_ready;
  logic [7:0]    intensity;
  logic [31:0]   argb_color;

  ring_glow_pixel_shader #(.COORD_BITS(CB), .FRAC_BITS(FB)) uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .column(column), .row(row),
    .out_valid(out_valid), .out_ready(out_ready),
    .intensity(intensity), .argb_color(argb_color)
  );

  pixel_t pixel_q[$];
  shade_t shade_q[$];
  longint frame_w, frame_h;
  int     send_idle_pct, recv_stall_pct;
  int     fail_count;
  logic   took;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > n) bits = bits >> 2;
    while (bits != 0) begin
      if (n >= res + bits) begin
        n = n - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned term_sq(longint num, longint h);
    longint t;
    t = (num * ONE) / h;
    if (t > TERM_MAX) t = TERM_MAX;
    if (t < -TERM_MAX) t = -TERM_MAX;
    if (t < 0) t = -t;
    return longint'(t) * longint'(t);
  endfunction

  function automatic logic [7:0] glow_of(longint x, longint y);
    longint d, r, g, e, q;
    if (frame_h == 0) return 8'd0;
    d = 2 * (x - y) + frame_h - frame_w;
    if (d == 0) return 8'd0;
    r = longint'(root_floor(term_sq(2 * x - frame_w, frame_h) +
                            term_sq(2 * y - frame_h, frame_h)));
    g = HALF + (HUNDREDTH * frame_h) / d;
    e = r - g;
    if (e < 0) e = -e;
    if (e == 0) return LEVEL_MAX;
    q = (TENTH * ONE) / e;
    if (q > ONE) q = ONE;
    return 8'((q * 255) >>> FB);
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (in_valid && !took) begin
        in_valid <= 1'b1;
      end else if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        pixel_t p;
        p = pixel_q.pop_front();
        column <= p.x;
        row <= p.y;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    took <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready) begin
      shade_t s;
      s.level = glow_of(longint'(column), longint'(row));
      s.argb = {ALPHA_OPAQUE, s.level, s.level, s.level};
      shade_q.push_back(s);
    end
    if (!rst && out_valid && out_ready) begin
      if (shade_q.size() == 0) begin
        $error("unexpected item: intensity %0d argb %h", intensity, argb_color);
        fail_count++;
      end else begin
        shade_t s;
        s = shade_q.pop_front();
        if (intensity !== s.level) begin
          $error("intensity: expected %0d, got %0d", s.level, intensity);
          fail_count++;
        end
        if (argb_color !== s.argb) begin
          $error("argb_color: expected %h, got %h", s.argb, argb_color);
          fail_count++;
        end
      end
    end
  end

  task automatic write_reg(logic idx, int value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CB'(value);
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_FRAME_WIDTH) frame_w = value;
    else frame_h = value;
  endtask

  task automatic add_pixel(int x, int y);
    pixel_t p;
    p.x = CB'(x);
    p.y = CB'(y);
    pixel_q.push_back(p);
  endtask

  task automatic wait_idle();
    while (pixel_q.size() > 0 || in_valid || shade_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_pixels(int count);
    int x, y, pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        x = $urandom_range(frame_w > 0 ? frame_w - 1 : 0);
        y = $urandom_range(frame_h > 0 ? frame_h - 1 : 0);
      end else if (pick < 70) begin
        // on the zero ring denominator line, where one exists
        y = $urandom_range(4095);
        x = y + (frame_w - frame_h) / 2;
        if (x < 0 || x > 4095) x = $urandom_range(4095);
      end else begin
        x = $urandom_range(4095);
        y = $urandom_range(4095);
      end
      add_pixel(x, y);
    end
  endtask

  initial begin
    int sizes[10][2];
    fail_count = 0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    frame_w = 800;
    frame_h = 600;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset frame: corners, center, ring, zero denominator line
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(4095, 0);
    add_pixel(0, 4095);
    add_pixel(400, 300);
    add_pixel(500, 400);
    add_pixel(600, 500);
    add_pixel(550, 300);
    add_pixel(400, 450);
    add_pixel(799, 599);
    add_pixel(2730, 1365);
    add_pixel(1365, 2730);
    wait_idle();

    sizes = '{'{1, 1}, '{4095, 4095}, '{4095, 1}, '{1, 4095}, '{800, 0},
              '{0, 600}, '{64, 48}, '{-1, -1}, '{-1, -1}, '{800, 600}};
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      write_reg(REG_FRAME_WIDTH, sizes[ph][0] < 0 ? $urandom_range(1, 4095) : sizes[ph][0]);
      write_reg(REG_FRAME_HEIGHT, sizes[ph][1] < 0 ? $urandom_range(1, 4095) : sizes[ph][1]);
      if (ph < 4) begin
        add_pixel(0, 0);
        add_pixel(4095, 4095);
      end
      random_pixels(ph == 0 ? 60 : 140);
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/rgps_pkg.sv
rtl/core/rgps_div_cell.sv
rtl/core/rgps_sqrt_cell.sv
rtl/core/ring_glow_pixel_shader.sv
verif/ring_glow_pixel_shader_tb.sv
